/* src/efcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// efcp_pkg
// Shared types, constants and helpers of the frame-to-chunk packetizer.
// ============================================================================
package efcp_pkg;

    // Packet geometry.
    localparam int MAX_CHANNELS  = 8;
    localparam int CHUNK_SAMPLES = 25;
    localparam int RESERVE_LIMIT = 8;
    localparam int FULL_LIMIT    = 12;

    localparam logic [7:0] HEADER_BYTE   = 8'h66;
    localparam logic [7:0] TRIGGER_MARK  = 8'hA5;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;
    localparam logic [7:0] CHUNK_LEN_BYTE = 8'(CHUNK_SAMPLES);

    // Request function codes.
    typedef enum logic [1:0] {
        FUNC_FRAME = 2'd0,
        FUNC_START = 2'd1,
        FUNC_STOP  = 2'd2
    } func_t;

    // Main part of a queued command, after any owed tail bytes.
    typedef enum logic [1:0] {
        BODY_NONE   = 2'd0,
        BODY_HEADER = 2'd1,
        BODY_PAIR   = 2'd2,
        BODY_TAIL   = 2'd3
    } body_kind_t;

    // One command describes every output byte caused by one input request.
    typedef struct packed {
        logic [3:0] a_cnt;   // owed tail bytes sent first
        logic [4:0] a_rem;   // tail countdown value at the first owed byte
        logic       a_pe;    // owed tail closes a packet
        body_kind_t kind;
        logic [3:0] b_cnt;   // tail bytes sent now (kind tail)
        logic [4:0] b_rem;   // tail countdown value at the first new tail byte
        logic       b_pe;    // new tail closes a packet
        logic [3:0] nibble;  // GPIO nibble used by tail bytes
        logic [7:0] d0;      // header: counter low, pair: low byte
        logic [7:0] d1;      // header: counter high, pair: high byte
    } cmd_t;

    // Byte of a sample tail, selected by the countdown of bytes still owed.
    function automatic logic [7:0] tail_byte(input logic [4:0] rem, input logic [3:0] nib);
        logic [7:0] b;
        b = 8'h00;
        if (rem == 5'd3 || rem == 5'd4)
        begin
            b = {4'h0, nib};
        end
        else if (rem == 5'd2)
        begin
            b = (nib != 4'h0) ? TRIGGER_MARK : 8'h00;
        end
        return b;
    endfunction

    // Number of bytes in the main part of a command.
    function automatic logic [3:0] body_len(input cmd_t c);
        logic [3:0] len;
        case (c.kind)
            BODY_HEADER: len = 4'd4;
            BODY_PAIR:   len = 4'd2;
            BODY_TAIL:   len = c.b_cnt;
            default:     len = 4'd0;
        endcase
        return len;
    endfunction

endpackage
`default_nettype wire

/* src/efcp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// efcp_front
// Accepts requests, tracks frame and chunk state, and queues one command
// per request that produces bytes.
// ============================================================================
module efcp_front
    import efcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] in_func,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_fstart,
    input  wire logic       cfg_valid,
    input  wire logic [3:0] cfg_data,
    input  wire logic       full,
    output logic            push,
    output cmd_t            push_cmd
);

    logic        streaming_reg, streaming_next;
    logic [15:0] counter_reg, counter_next;
    logic [4:0]  sic_reg, sic_next;
    logic [4:0]  pos_reg, pos_next;
    logic [1:0]  part_reg, part_next;
    logic [2:0]  chan_reg, chan_next;
    logic [7:0]  held_reg, held_next;
    logic [3:0]  nib_reg, nib_next;
    logic [4:0]  tail_rem_reg, tail_rem_next;
    logic        tail_pe_reg, tail_pe_next;
    logic [3:0]  nch_reg;

    logic        accept;
    func_t       func;
    logic [3:0]  n_act;
    logic [4:0]  tail_len;
    logic [3:0]  a_cnt;
    logic [4:0]  rem_after_a;
    logic [3:0]  b_lim;
    logic [3:0]  b_cnt;
    logic [4:0]  p;
    logic        active;
    logic        frame_end;
    logic [5:0]  sic_inc;
    cmd_t        cmd;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign func     = func_t'(in_func);

    always_comb
    begin
        if (nch_reg == 4'd0)
        begin
            n_act = 4'd1;
        end
        else if (nch_reg > 4'(MAX_CHANNELS))
        begin
            n_act = 4'(MAX_CHANNELS);
        end
        else
        begin
            n_act = nch_reg;
        end
    end

    assign tail_len    = {4'(MAX_CHANNELS) - n_act, 1'b0} + 5'd4;
    assign a_cnt       = (tail_rem_reg > 5'(RESERVE_LIMIT)) ? 4'(RESERVE_LIMIT)
                                                             : tail_rem_reg[3:0];
    assign rem_after_a = tail_rem_reg - {1'b0, a_cnt};
    assign b_lim       = 4'(FULL_LIMIT) - a_cnt;
    assign b_cnt       = (tail_len > {1'b0, b_lim}) ? b_lim : tail_len[3:0];
    assign sic_inc     = {1'b0, sic_reg} + 6'd1;

    always_comb
    begin
        streaming_next = streaming_reg;
        counter_next   = counter_reg;
        sic_next       = sic_reg;
        pos_next       = pos_reg;
        part_next      = part_reg;
        chan_next      = chan_reg;
        held_next      = held_reg;
        nib_next       = nib_reg;
        tail_pe_next   = tail_pe_reg;
        frame_end      = 1'b0;
        active         = 1'b0;
        p              = in_fstart ? 5'd0 : pos_reg;

        cmd        = '0;
        cmd.a_cnt  = a_cnt;
        cmd.a_rem  = tail_rem_reg;
        cmd.a_pe   = tail_pe_reg;
        cmd.kind   = BODY_NONE;
        cmd.nibble = nib_reg;

        case (func)
            FUNC_START:
            begin
                streaming_next = 1'b1;
                counter_next   = 16'd0;
                sic_next       = 5'd0;
                pos_next       = 5'd0;
            end
            FUNC_STOP:
            begin
                streaming_next = 1'b0;
                pos_next       = 5'd0;
            end
            FUNC_FRAME:
            begin
                active = streaming_reg && (in_fstart || pos_reg != 5'd0);
            end
            default:
            begin
                active = 1'b0;
            end
        endcase

        if (active)
        begin
            if (p == 5'd0)
            begin
                if (sic_reg == 5'd0)
                begin
                    cmd.kind = BODY_HEADER;
                    cmd.d0   = counter_reg[7:0];
                    cmd.d1   = counter_reg[15:8];
                end
            end
            else if (p == 5'd2)
            begin
                nib_next  = in_byte[3:0] & NIBBLE_MASK;
                part_next = 2'd0;
                chan_next = 3'd0;
            end
            else if (p >= 5'd3)
            begin
                if (part_reg == 2'd0)
                begin
                    held_next = in_byte;
                    part_next = 2'd1;
                end
                else if (part_reg == 2'd1)
                begin
                    cmd.kind  = BODY_PAIR;
                    cmd.d0    = in_byte;
                    cmd.d1    = held_reg;
                    part_next = 2'd2;
                end
                else
                begin
                    part_next = 2'd0;
                    chan_next = chan_reg + 3'd1;
                    if ({1'b0, chan_reg} + 4'd1 >= n_act)
                    begin
                        frame_end    = 1'b1;
                        counter_next = counter_reg + 16'd1;
                        if (sic_inc >= 6'(CHUNK_SAMPLES))
                        begin
                            sic_next     = 5'd0;
                            tail_pe_next = 1'b1;
                        end
                        else
                        begin
                            sic_next     = sic_inc[4:0];
                            tail_pe_next = 1'b0;
                        end
                        cmd.kind  = BODY_TAIL;
                        cmd.b_cnt = b_cnt;
                        cmd.b_rem = tail_len;
                        cmd.b_pe  = tail_pe_next;
                    end
                end
            end
            pos_next = frame_end ? 5'd0 : p + 5'd1;
        end

        tail_rem_next = frame_end ? (tail_len - {1'b0, b_cnt}) : rem_after_a;
    end

    assign push     = accept && (cmd.a_cnt != 4'd0 || cmd.kind != BODY_NONE);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            streaming_reg <= 1'b0;
            counter_reg   <= 16'd0;
            sic_reg       <= 5'd0;
            pos_reg       <= 5'd0;
            part_reg      <= 2'd0;
            chan_reg      <= 3'd0;
            held_reg      <= 8'd0;
            nib_reg       <= 4'd0;
            tail_rem_reg  <= 5'd0;
            tail_pe_reg   <= 1'b0;
            nch_reg       <= 4'd4;
        end
        else
        begin
            if (cfg_valid)
            begin
                nch_reg <= cfg_data;
            end
            if (accept)
            begin
                streaming_reg <= streaming_next;
                counter_reg   <= counter_next;
                sic_reg       <= sic_next;
                pos_reg       <= pos_next;
                part_reg      <= part_next;
                chan_reg      <= chan_next;
                held_reg      <= held_next;
                nib_reg       <= nib_next;
                tail_rem_reg  <= tail_rem_next;
                tail_pe_reg   <= tail_pe_next;
            end
        end
    end

`ifndef SYNTH
    a_push_not_full : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_owed_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        push |-> push_cmd.a_cnt <= 4'(RESERVE_LIMIT))
        else $error("owed tail longer than the reserve");

    a_step_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_cmd.kind == BODY_TAIL) |->
            ({1'b0, push_cmd.a_cnt} + {1'b0, push_cmd.b_cnt} <= 5'(FULL_LIMIT)))
        else $error("one request produces more bytes than allowed");
`endif

endmodule
`default_nettype wire

/* src/efcp_cmd_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// efcp_cmd_fifo
// Short command queue between the request front end and the byte back end.
// ============================================================================
module efcp_cmd_fifo
    import efcp_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output cmd_t      head,
    output logic      empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

/* src/efcp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// efcp_back
// Expands queued commands into packet bytes through an output register, one
// byte per cycle while a command is underway and the output is not stalled.
// ============================================================================
module efcp_back
    import efcp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       empty,
    input  wire cmd_t       head,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            out_last,
    output logic            out_pe
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_BODY  = 3'b100
    } back_state_t;

    back_state_t st_reg, st_next;
    cmd_t        cmd_reg, cmd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [4:0]  rem_reg, rem_next;
    logic [1:0]  idx_reg, idx_next;
    logic        ovalid_reg, ovalid_next;
    logic [7:0]  obyte_reg, obyte_next;
    logic        olast_reg, olast_next;
    logic        ope_reg, ope_next;

    logic        slot_free;
    logic        gen;
    logic [7:0]  gen_byte;
    logic        gen_last;
    logic        gen_pe;

    assign slot_free = !ovalid_reg || out_ready;

    always_comb
    begin
        st_next  = st_reg;
        cmd_next = cmd_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        idx_next = idx_reg;
        pop      = 1'b0;
        gen      = 1'b0;
        gen_byte = 8'h00;
        gen_last = 1'b0;
        gen_pe   = 1'b0;

        case (st_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    idx_next = 2'd0;
                    if (head.a_cnt != 4'd0)
                    begin
                        st_next  = ST_DRAIN;
                        cnt_next = head.a_cnt;
                        rem_next = head.a_rem;
                    end
                    else
                    begin
                        st_next  = ST_BODY;
                        cnt_next = body_len(head);
                        rem_next = head.b_rem;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (slot_free)
                begin
                    gen      = 1'b1;
                    gen_byte = tail_byte(rem_reg, cmd_reg.nibble);
                    gen_pe   = (rem_reg == 5'd1) && cmd_reg.a_pe;
                    gen_last = (cnt_reg == 4'd1) && (cmd_reg.kind == BODY_NONE);
                    cnt_next = cnt_reg - 4'd1;
                    rem_next = rem_reg - 5'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        if (cmd_reg.kind == BODY_NONE)
                        begin
                            st_next = ST_IDLE;
                        end
                        else
                        begin
                            st_next  = ST_BODY;
                            cnt_next = body_len(cmd_reg);
                            rem_next = cmd_reg.b_rem;
                            idx_next = 2'd0;
                        end
                    end
                end
            end
            ST_BODY:
            begin
                if (slot_free)
                begin
                    gen      = 1'b1;
                    gen_last = (cnt_reg == 4'd1);
                    case (cmd_reg.kind)
                        BODY_HEADER:
                        begin
                            case (idx_reg)
                                2'd0:    gen_byte = HEADER_BYTE;
                                2'd1:    gen_byte = cmd_reg.d0;
                                2'd2:    gen_byte = cmd_reg.d1;
                                default: gen_byte = CHUNK_LEN_BYTE;
                            endcase
                        end
                        BODY_PAIR:
                        begin
                            gen_byte = (idx_reg == 2'd0) ? cmd_reg.d0 : cmd_reg.d1;
                        end
                        BODY_TAIL:
                        begin
                            gen_byte = tail_byte(rem_reg, cmd_reg.nibble);
                            gen_pe   = (rem_reg == 5'd1) && cmd_reg.b_pe;
                        end
                        default:
                        begin
                            gen_byte = 8'h00;
                        end
                    endcase
                    cnt_next = cnt_reg - 4'd1;
                    rem_next = rem_reg - 5'd1;
                    idx_next = idx_reg + 2'd1;
                    if (cnt_reg == 4'd1)
                    begin
                        st_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase

        ovalid_next = ovalid_reg;
        obyte_next  = obyte_reg;
        olast_next  = olast_reg;
        ope_next    = ope_reg;
        if (gen)
        begin
            ovalid_next = 1'b1;
            obyte_next  = gen_byte;
            olast_next  = gen_last;
            ope_next    = gen_pe;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            cnt_reg    <= 4'd0;
            rem_reg    <= 5'd0;
            idx_reg    <= 2'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            cnt_reg    <= cnt_next;
            rem_reg    <= rem_next;
            idx_reg    <= idx_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        obyte_reg <= obyte_next;
        olast_reg <= olast_next;
        ope_reg   <= ope_next;
    end

    assign out_valid = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;
    assign out_pe    = ope_reg;

`ifndef SYNTH
    a_pop_from_idle : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (st_reg == ST_IDLE) && !empty)
        else $error("command taken while another is in progress");

    a_count_live : assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_DRAIN || st_reg == ST_BODY) |-> cnt_reg != 4'd0)
        else $error("active command with no bytes left");

    a_pe_zero_byte : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_pe) |-> out_byte == 8'h00)
        else $error("packet end marked on a nonzero byte");
`endif

endmodule
`default_nettype wire

/* src/eeg_frame_to_chunk_packetizer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// eeg_frame_to_chunk_packetizer
// Turns converter read-frame bytes into chunk packet bytes.
// ============================================================================
//
//  Channel  | Direction | Handshake              | Contents
//  ---------+-----------+------------------------+------------------------------
//  s_axis   | in        | s_axis_tvalid/tready   | frame byte, function, frame start
//  m_axis   | out       | m_axis_tvalid/tready   | packet byte, end of request, packet end
//  cfg      | in        | cfg_valid/cfg_ready    | active channel count
//
// The front end takes one request per cycle while the command queue has room
// and turns it into at most one queued command. The back end loads a command
// in its idle state and then sends one byte per cycle while m_axis is not
// stalled, taking the next command only once the last is done; the back end
// sets the sustained rate. Reset (rst_n low, asynchronous) stops streaming,
// clears the counters, empties the queue and sets the channel count to four.
// A stalled m_axis holds its byte in the output register; the queue then
// fills and s_axis_tready falls only once it is full.
//
// Packet layout: 0x66, start sample index (low byte first), chunk length,
// then per sample eight channels of two bytes (top 16 bits, low byte first,
// absent channels zero), the GPIO nibble twice, 0xA5 when the nibble is
// nonzero (else zero), and a closing zero. A long sample tail that does not
// fit in one request's bytes is finished first on the next request.
// ============================================================================
module eeg_frame_to_chunk_packetizer
    import efcp_pkg::*;
#(
    parameter int CMD_QUEUE_DEPTH = 4
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Input requests.
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] frame_byte
    input  wire logic [2:0] s_axis_tuser,   // [1:0] func, [2] frame_start
    // Packet bytes.
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,
    output logic [0:0]      m_axis_tuser,   // [0] packet_end
    // Channel count register.
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [3:0] cfg_data
);

    logic cfg_write;
    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;
    logic q_pop;
    cmd_t q_head;
    logic q_empty;
    logic pe_bit;

    // Always taken; the user must write the channel count only while idle; not enforced.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    efcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser[1:0]),
        .in_byte   (s_axis_tdata),
        .in_fstart (s_axis_tuser[2]),
        .cfg_valid (cfg_write),
        .cfg_data  (cfg_data),
        .full      (q_full),
        .push      (q_push),
        .push_cmd  (q_push_cmd)
    );

    efcp_cmd_fifo #(
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    efcp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_pe    (pe_bit)
    );

    assign m_axis_tuser = pe_bit;

`ifndef SYNTH
    a_pe_is_tail_end : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tdata == 8'h00)
        else $error("packet end on a byte other than a sample trailer");

    a_no_output_from_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (q_empty && !q_push) |=> !q_pop)
        else $error("command taken from an empty queue");

    a_ready_tracks_queue : assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == !q_full)
        else $error("input ready out of step with the queue");
`endif

endmodule
`default_nettype wire

/* tb/tb_eeg_frame_to_chunk_packetizer.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_eeg_frame_to_chunk_packetizer
// Self-checking bench for the frame-to-chunk packetizer.
// ============================================================================
// Converter read frames are pushed into s_axis one byte per request, and every
// packet byte that leaves m_axis is compared against a cycle-free predictor of
// the packet format held in a small scoreboard class. The run starts with a
// hand-written sequence, then walks through several channel-count settings
// (zero, one, fifteen and values in between) with mostly well-formed random
// frames, some cut-short frames, unsynced bytes, unused function codes and
// stop/start pairs. Both sides of the block are stalled in random bursts.
// ============================================================================
module tb_eeg_frame_to_chunk_packetizer;
    import efcp_pkg::*;

    // Idle cycles allowed after the last expected byte before the block is
    // taken as quiet.
    localparam int SETTLE_CYCLES = 16;
    // Cycles without any handshake on any channel before the run is declared hung.
    localparam int HANG_LIMIT    = 1000;
    localparam int NUM_PHASES    = 7;

    // The one function code the block has no meaning for.
    localparam func_t FUNC_UNUSED = func_t'(2'd3);

    typedef enum int {
        NOISE_UNSYNCED,
        NOISE_UNUSED_FUNC,
        NOISE_RESTART
    } noise_kind_t;

    // One expected packet byte with its side-band flags.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       pkt_end;
    } pkt_byte_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the packetizer state and the bytes still owed.
    // ------------------------------------------------------------------------
    class chunk_scoreboard;
        bit        streaming;
        bit [15:0] sample_idx;
        bit [4:0]  chunk_fill;
        bit [4:0]  frame_pos;
        bit [7:0]  hi_byte;
        bit [3:0]  nibble;
        bit [4:0]  tail_left;
        bit        tail_closes;
        bit [3:0]  chan_reg;
        int        step_cnt;
        pkt_byte_t expected_bytes[$];
        int        errors;
        int        bytes_checked;
        int        packets_closed;

        function new();
            streaming      = 1'b0;
            sample_idx     = '0;
            chunk_fill     = '0;
            frame_pos      = '0;
            hi_byte        = '0;
            nibble         = '0;
            tail_left      = '0;
            tail_closes    = 1'b0;
            chan_reg       = 4'd4;
            errors         = 0;
            bytes_checked  = 0;
            packets_closed = 0;
        endfunction

        function void set_channels(bit [3:0] v);
            chan_reg = v;
        endfunction

        // Channel count actually used: zero means one, large values clip.
        function int lanes();
            int n;
            n = chan_reg;
            if (n < 1)
                n = 1;
            if (n > MAX_CHANNELS)
                n = MAX_CHANNELS;
            return n;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void push_byte(bit [7:0] b, bit pe);
            pkt_byte_t e;
            e.data    = b;
            e.last    = 1'b0;
            e.pkt_end = pe;
            expected_bytes.push_back(e);
            step_cnt++;
        endfunction

        // Sends owed sample-tail bytes until the tail is done or the request
        // has produced as many bytes as the limit allows.
        function void flush_tail(int limit);
            bit [7:0] b;
            while (tail_left > 0 && step_cnt < limit)
            begin
                if (tail_left > 4)
                    b = 8'h00;
                else if (tail_left >= 3)
                    b = {4'h0, nibble};
                else if (tail_left == 2)
                    b = (nibble != 4'h0) ? TRIGGER_MARK : 8'h00;
                else
                    b = 8'h00;
                push_byte(b, tail_left == 1 && tail_closes);
                if (tail_left == 1)
                    tail_closes = 1'b0;
                tail_left = tail_left - 1;
            end
        endfunction

        function void take_frame_byte(bit [7:0] b, bit fs);
            int n;
            int p;
            int q;
            n = lanes();
            if (fs)
                frame_pos = '0;
            if (!fs && frame_pos == 0)
                return;
            p = frame_pos;
            if (p == 0)
            begin
                if (chunk_fill == 0)
                begin
                    push_byte(HEADER_BYTE, 1'b0);
                    push_byte(sample_idx[7:0], 1'b0);
                    push_byte(sample_idx[15:8], 1'b0);
                    push_byte(CHUNK_LEN_BYTE, 1'b0);
                end
            end
            else if (p == 2)
            begin
                nibble = b[3:0] & NIBBLE_MASK;
            end
            else if (p >= 3)
            begin
                q = p - 3;
                if (q % 3 == 0)
                begin
                    hi_byte = b;
                end
                else if (q % 3 == 1)
                begin
                    push_byte(b, 1'b0);
                    push_byte(hi_byte, 1'b0);
                end
                else if (q / 3 + 1 >= n)
                begin
                    // Last byte of the frame: zero fill and trailer follow.
                    tail_left  = 5'(2 * (MAX_CHANNELS - n) + 4);
                    sample_idx = sample_idx + 1;
                    chunk_fill = chunk_fill + 1;
                    if (chunk_fill >= CHUNK_SAMPLES)
                    begin
                        chunk_fill  = '0;
                        tail_closes = 1'b1;
                    end
                    else
                    begin
                        tail_closes = 1'b0;
                    end
                    frame_pos = '0;
                    flush_tail(FULL_LIMIT);
                    return;
                end
            end
            frame_pos = 5'(p + 1);
        endfunction

        // Records one accepted request and queues the bytes it causes.
        function void note_request(func_t f, bit [7:0] b, bit fs);
            pkt_byte_t e;
            int first;
            first    = expected_bytes.size();
            step_cnt = 0;
            flush_tail(RESERVE_LIMIT);
            case (f)
                FUNC_START:
                begin
                    streaming  = 1'b1;
                    sample_idx = '0;
                    chunk_fill = '0;
                    frame_pos  = '0;
                end
                FUNC_STOP:
                begin
                    streaming = 1'b0;
                    frame_pos = '0;
                end
                FUNC_FRAME:
                begin
                    if (streaming)
                        take_frame_byte(b, fs);
                end
                default:
                begin
                end
            endcase
            if (expected_bytes.size() > first)
            begin
                e = expected_bytes.pop_back();
                e.last = 1'b1;
                expected_bytes.push_back(e);
            end
        endfunction

        function void check_byte(logic [7:0] data, logic lst, logic pe);
            pkt_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                $error("packet byte 0x%02h arrived with nothing expected", data);
                errors++;
                return;
            end
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (data !== want.data)
            begin
                $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, data);
                errors++;
            end
            if (lst !== want.last)
            begin
                $error("last: expected %0b, actual %0b", want.last, lst);
                errors++;
            end
            if (pe !== want.pkt_end)
            begin
                $error("packet_end: expected %0b, actual %0b", want.pkt_end, pe);
                errors++;
            end
            if (want.pkt_end)
                packets_closed++;
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block's ports. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;
    logic [2:0] s_axis_tuser  = '0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;
    logic [0:0] m_axis_tuser;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [3:0] cfg_data      = '0;

    chunk_scoreboard sb = new();

    // Random idling on both sides is switched off for some stretches.
    bit idle_on       = 1'b1;
    int stall_left    = 0;
    int quiet_cycles  = 0;
    int request_count = 0;

    // A hand-built frame for four channels: full-scale, zero, mid-scale and a
    // plain pattern channel, with the GPIO nibble all ones.
    logic [7:0] hand_frame [15] = '{
        8'hC0, 8'h00, 8'hFF,
        8'hFF, 8'hFF, 8'hFF,
        8'h00, 8'h00, 8'h00,
        8'h80, 8'h01, 8'h7F,
        8'h12, 8'h34, 8'h56
    };

    int       phase_cfg    [NUM_PHASES] = '{1, 15, 0, 3, 9, 2, 6};
    int       phase_budget [NUM_PHASES] = '{160, 40, 30, 30, 30, 30, 30};

    always #5 clk = ~clk;

    eeg_frame_to_chunk_packetizer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Packet byte sink. Values are sampled at the edge, before any register of
    // the block updates, and tready is then chosen for the next cycle. Stalls
    // come in bursts of random length.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
        if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left    <= $urandom_range(0, 11);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Hang detection: the count restarts whenever any channel completes a handshake.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= HANG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Request driver. Called at a rising edge; returns at the edge where the
    // request was taken. Valid stays high between back-to-back requests and is
    // only dropped for a random gap or while the bench waits for the output to drain.
    // ------------------------------------------------------------------------
    task automatic send_req(input func_t f, input logic [7:0] b, input logic fs);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {fs, f};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_request(f, b, fs);
        request_count++;
    endtask

    // Lets every expected byte drain, then waits out the settle time.
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_channels(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_channels(v);
        cfg_valid <= 1'b0;
    endtask

    // Sends one frame with random content; a nonzero cut sends only its first
    // bytes, so the next frame start arrives in the middle of it.
    task automatic send_frame(input int lanes_n, input int cut);
        int len;
        logic [7:0] b;
        len = 3 + 3 * lanes_n;
        if (cut > 0 && cut < len)
            len = cut;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            // The GPIO nibble is often zero so both trailer forms show up.
            if (i == 2 && $urandom_range(0, 2) == 0)
                b[3:0] = 4'h0;
            send_req(FUNC_FRAME, b, i == 0);
        end
    endtask

    task automatic send_noise(input bit allow_stop);
        noise_kind_t kind;
        kind = noise_kind_t'($urandom_range(0, allow_stop ? 2 : 1));
        case (kind)
            NOISE_UNSYNCED:
                send_req(FUNC_FRAME, 8'($urandom_range(0, 255)), 1'b0);
            NOISE_UNUSED_FUNC:
                send_req(FUNC_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            default:
            begin
                // Stop, a few bytes that must be dropped, then a fresh start.
                send_req(FUNC_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 2))
                    send_req(FUNC_FRAME, 8'($urandom_range(0, 255)),
                             1'($urandom_range(0, 1)));
                send_req(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int used;
        int n;
        int cut;
        int pick;
        bit held;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hand-written opening at the reset channel count of four.
        send_req(FUNC_FRAME, 8'hFF, 1'b1);          // not streaming yet: dropped
        send_req(FUNC_UNUSED, 8'h00, 1'b0);         // unused code: dropped
        send_req(FUNC_START, 8'h5A, 1'b1);
        send_req(FUNC_FRAME, 8'h3C, 1'b0);          // no frame start seen: dropped
        for (int i = 0; i < 15; i++)
            send_req(FUNC_FRAME, hand_frame[i], i == 0);
        // A frame broken off after the first high byte, then a frame start
        // in the middle of it, then a stop that leaves the packet open.
        send_req(FUNC_FRAME, 8'hC0, 1'b1);
        send_req(FUNC_FRAME, 8'h01, 1'b0);
        send_req(FUNC_FRAME, 8'hF0, 1'b0);
        send_req(FUNC_FRAME, 8'h7E, 1'b0);
        send_req(FUNC_FRAME, 8'hAA, 1'b1);
        send_req(FUNC_STOP, 8'hFF, 1'b1);

        // Random phases, one per channel setting. The first phase runs long at
        // one channel so that whole packets close, including the case where the
        // closing sample's tail spills into the following request.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_quiet();
            idle_on = (ph != 3) && (ph != NUM_PHASES - 1);
            write_channels(4'(phase_cfg[ph]));
            n = sb.lanes();
            send_req(FUNC_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            used = 0;
            held = 1'b0;
            while (used < phase_budget[ph])
            begin
                // Once in the long phase, hold off until the output has caught up.
                if (ph == 0 && !held && used >= 80)
                begin
                    wait_quiet();
                    held = 1'b1;
                end
                pick = $urandom_range(0, 9);
                if (pick < 8)
                begin
                    send_frame(n, 0);
                    used += 3 + 3 * n;
                end
                else if (pick == 8)
                begin
                    cut = $urandom_range(1, 2 + 3 * n);
                    send_frame(n, cut);
                    used += cut;
                end
                else
                begin
                    send_noise(ph != 0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d requests over %0d channel settings; %0d packet bytes checked.",
                 request_count, NUM_PHASES + 1, sb.bytes_checked);
        $display("Packets closed: %0d; mismatches: %0d.", sb.packets_closed, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
src/efcp_pkg.sv
src/efcp_front.sv
src/efcp_cmd_fifo.sv
src/efcp_back.sv
src/eeg_frame_to_chunk_packetizer.sv
tb/tb_eeg_frame_to_chunk_packetizer.sv
